@@ rtl/core/ffba_pkg.sv @@
package ffba_pkg;

    // Heap geometry. Neither value sets a width, so both are fixed here.
    localparam int unsigned HEAP_BYTES   = 65536;
    localparam int unsigned HEADER_BYTES = 16;

    localparam logic [17:0] HEAP_LIMIT = 18'(HEAP_BYTES);
    localparam logic [15:0] HDR16      = 16'(HEADER_BYTES);
    localparam logic [16:0] HDR17      = 17'(HEADER_BYTES);
    localparam logic [17:0] HDR18      = 18'(HEADER_BYTES);

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] size;
        logic        free;
    } t_entry;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_EXHAUSTED  = 2'd1,
        STS_TABLE_FULL = 2'd2,
        STS_UNKNOWN    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_SHU_RD,
        S_SHU_WR,
        S_SPLIT_REM,
        S_SPLIT_CUR,
        S_APPEND,
        S_NX_RD,
        S_NX_CHK,
        S_CUR_WR,
        S_SHD_RD,
        S_SHD_WR,
        S_PV,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_IDX,
        OP_NEXT,
        OP_FIN_UNKNOWN,
        OP_FIN_FULL,
        OP_HIT_ALLOC,
        OP_HIT_FREE,
        OP_SHU_RD,
        OP_SHU_WR,
        OP_WR_REM,
        OP_WR_ALLOC,
        OP_APPEND,
        OP_NX_RD,
        OP_MERGE_NX,
        OP_WR_CUR,
        OP_SHD_RD,
        OP_SHD_WR,
        OP_SHD_END,
        OP_MERGE_PV,
        OP_FIN_OK,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic is_free_req;
        logic idx_end;
        logic hit;
        logic tbl_full;
        logic has_next;
        logic next_free;
        logic merged;
        logic shu_end;
        logic shd_end;
        logic pv_merge;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/ffba_ram.sv @@
module ffba_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/ffba_dp.sv @@
module ffba_dp #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffba_pkg::t_ctl  i_ctl,
    output ffba_pkg::t_sts  o_sts,
    input  logic            i_action,
    input  logic [15:0]     i_request_size,
    input  logic [15:0]     i_block_address,
    input  logic            i_out_stall,
    output logic            o_valid,
    output logic [15:0]     o_data_address,
    output logic [1:0]      o_status
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    // control state
    logic [CW-1:0] r_cnt, n_cnt;
    logic [16:0]   r_brk, n_brk;
    logic          r_ovalid, n_ovalid;
    // payload
    logic          r_action, n_action;
    logic [15:0]   r_req, n_req;
    logic [15:0]   r_addr, n_addr;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_k, n_k;
    logic          r_merged, n_merged;
    ffba_pkg::t_entry  r_cur, n_cur;
    ffba_pkg::t_entry  r_prv, n_prv;
    logic [15:0]       r_res_addr, n_res_addr;
    ffba_pkg::t_status r_res_sts, n_res_sts;
    logic [15:0]       r_odata, n_odata;
    ffba_pkg::t_status r_osts, n_osts;

    ffba_pkg::t_entry rd_data, wdata;
    logic [IW-1:0]    waddr, raddr;
    logic             we;

    logic [16:0] need;
    logic [CW:0] idx_p1, k_p1;
    logic [CW-1:0] idx_m1, k_m1;
    logic [16:0] cur_hdr;
    logic [17:0] app_end, app_hdr;
    logic        exhausted, cnt_full;

    assign need    = {1'b0, r_req} + ffba_pkg::HDR17;
    assign idx_p1  = {1'b0, r_idx} + {1'b0, ONE};
    assign k_p1    = {1'b0, r_k} + {1'b0, ONE};
    assign idx_m1  = r_idx - ONE;
    assign k_m1    = r_k - ONE;
    assign cur_hdr = {1'b0, rd_data.start} + ffba_pkg::HDR17;
    assign app_end = {1'b0, r_brk} + {1'b0, need};
    assign app_hdr = {1'b0, r_brk} + ffba_pkg::HDR18;
    assign exhausted = (app_end > ffba_pkg::HEAP_LIMIT) || (app_hdr >= ffba_pkg::HEAP_LIMIT);
    assign cnt_full  = r_cnt >= CNT_MAX;

    always_comb begin
        o_sts.is_free_req = r_action;
        o_sts.idx_end     = r_idx >= r_cnt;
        o_sts.hit         = r_action ? (!rd_data.free && cur_hdr == {1'b0, r_addr})
                                     : (rd_data.free && {1'b0, rd_data.size} >= need);
        o_sts.tbl_full    = cnt_full;
        o_sts.has_next    = idx_p1 < {1'b0, r_cnt};
        o_sts.next_free   = rd_data.free;
        o_sts.merged      = r_merged;
        o_sts.shu_end     = {1'b0, r_k} == idx_p1;
        o_sts.shd_end     = k_p1 >= {1'b0, r_cnt};
        o_sts.pv_merge    = (r_idx != '0) && r_prv.free;
        o_sts.out_free    = !r_ovalid || !i_out_stall;
    end

    // Table memory port control.
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rd_data;
        raddr = '0;
        case (i_ctl.op)
            ffba_pkg::OP_RD_IDX: raddr = r_idx[IW-1:0];
            ffba_pkg::OP_SHU_RD: raddr = k_m1[IW-1:0];
            ffba_pkg::OP_NX_RD:  raddr = idx_p1[IW-1:0];
            ffba_pkg::OP_SHD_RD: raddr = k_p1[IW-1:0];
            ffba_pkg::OP_SHU_WR, ffba_pkg::OP_SHD_WR: begin
                we    = 1'b1;
                waddr = r_k[IW-1:0];
            end
            ffba_pkg::OP_WR_REM: begin
                we    = 1'b1;
                waddr = idx_p1[IW-1:0];
                wdata = '{start: r_cur.start + need[15:0],
                          size:  r_cur.size - need[15:0],
                          free:  1'b1};
            end
            ffba_pkg::OP_WR_ALLOC: begin
                we    = 1'b1;
                waddr = r_idx[IW-1:0];
                wdata = '{start: r_cur.start, size: r_req, free: 1'b0};
            end
            ffba_pkg::OP_APPEND: begin
                we    = !exhausted && !cnt_full;
                waddr = r_cnt[IW-1:0];
                wdata = '{start: r_brk[15:0], size: r_req, free: 1'b0};
            end
            ffba_pkg::OP_WR_CUR: begin
                we    = 1'b1;
                waddr = r_idx[IW-1:0];
                wdata = r_cur;
            end
            ffba_pkg::OP_MERGE_PV: begin
                we    = 1'b1;
                waddr = idx_m1[IW-1:0];
                wdata = '{start: r_prv.start,
                          size:  r_prv.size + ffba_pkg::HDR16 + r_cur.size,
                          free:  1'b1};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_brk      = r_brk;
        n_action   = r_action;
        n_req      = r_req;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_k        = r_k;
        n_merged   = r_merged;
        n_cur      = r_cur;
        n_prv      = r_prv;
        n_res_addr = r_res_addr;
        n_res_sts  = r_res_sts;
        n_odata    = r_odata;
        n_osts     = r_osts;
        n_ovalid   = (i_ctl.op == ffba_pkg::OP_EMIT) ? 1'b1 : (r_ovalid && i_out_stall);
        case (i_ctl.op)
            ffba_pkg::OP_LOAD: begin
                n_action = i_action;
                n_req    = i_request_size;
                n_addr   = i_block_address;
                n_idx    = '0;
                n_merged = 1'b0;
            end
            ffba_pkg::OP_NEXT: begin
                n_prv = rd_data;
                n_idx = idx_p1[CW-1:0];
            end
            ffba_pkg::OP_FIN_UNKNOWN: begin
                n_res_addr = '0;
                n_res_sts  = ffba_pkg::STS_UNKNOWN;
            end
            ffba_pkg::OP_FIN_FULL: begin
                n_res_addr = '0;
                n_res_sts  = ffba_pkg::STS_TABLE_FULL;
            end
            ffba_pkg::OP_HIT_ALLOC: begin
                n_cur = rd_data;
                n_k   = r_cnt;
            end
            ffba_pkg::OP_HIT_FREE: begin
                n_cur      = rd_data;
                n_cur.free = 1'b1;
            end
            ffba_pkg::OP_SHU_WR: n_k = k_m1;
            ffba_pkg::OP_WR_ALLOC: begin
                n_cnt      = r_cnt + ONE;
                n_res_addr = r_cur.start + ffba_pkg::HDR16;
                n_res_sts  = ffba_pkg::STS_OK;
            end
            ffba_pkg::OP_APPEND: begin
                n_res_addr = '0;
                if (exhausted) begin
                    n_res_sts = ffba_pkg::STS_EXHAUSTED;
                end else if (cnt_full) begin
                    n_res_sts = ffba_pkg::STS_TABLE_FULL;
                end else begin
                    n_cnt      = r_cnt + ONE;
                    n_brk      = app_end[16:0];
                    n_res_addr = app_hdr[15:0];
                    n_res_sts  = ffba_pkg::STS_OK;
                end
            end
            ffba_pkg::OP_MERGE_NX: begin
                n_cur.size = r_cur.size + ffba_pkg::HDR16 + rd_data.size;
                n_merged   = 1'b1;
                n_k        = idx_p1[CW-1:0];
            end
            ffba_pkg::OP_SHD_WR:  n_k = k_p1[CW-1:0];
            ffba_pkg::OP_SHD_END: n_cnt = r_cnt - ONE;
            ffba_pkg::OP_MERGE_PV: begin
                // Clearing the index makes the next predecessor check fail.
                n_k   = r_idx;
                n_idx = '0;
            end
            ffba_pkg::OP_FIN_OK: begin
                n_res_addr = '0;
                n_res_sts  = ffba_pkg::STS_OK;
            end
            ffba_pkg::OP_EMIT: begin
                n_odata = r_res_addr;
                n_osts  = r_res_sts;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_brk    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_brk    <= n_brk;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_merged   <= n_merged;
        r_cur      <= n_cur;
        r_prv      <= n_prv;
        r_res_addr <= n_res_addr;
        r_res_sts  <= n_res_sts;
        r_odata    <= n_odata;
        r_osts     <= n_osts;
    end

    ffba_ram #(
        .WIDTH ($bits(ffba_pkg::t_entry)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign o_valid        = r_ovalid;
    assign o_data_address = r_odata;
    assign o_status       = r_osts;

endmodule

@@ rtl/core/ffba_ctrl.sv @@
module ffba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ffba_pkg::t_sts i_sts,
    output ffba_pkg::t_ctl o_ctl,
    output logic           o_in_stall
);

    ffba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_IDLE:      if (i_valid) n_state = ffba_pkg::S_RD;
            ffba_pkg::S_RD: begin
                if (!i_sts.idx_end)        n_state = ffba_pkg::S_CHK;
                else if (i_sts.is_free_req) n_state = ffba_pkg::S_DONE;
                else                       n_state = ffba_pkg::S_APPEND;
            end
            ffba_pkg::S_CHK: begin
                if (!i_sts.hit)            n_state = ffba_pkg::S_RD;
                else if (i_sts.is_free_req) n_state = ffba_pkg::S_NX_RD;
                else if (i_sts.tbl_full)   n_state = ffba_pkg::S_DONE;
                else                       n_state = ffba_pkg::S_SHU_RD;
            end
            ffba_pkg::S_SHU_RD:
                n_state = i_sts.shu_end ? ffba_pkg::S_SPLIT_REM : ffba_pkg::S_SHU_WR;
            ffba_pkg::S_SHU_WR:    n_state = ffba_pkg::S_SHU_RD;
            ffba_pkg::S_SPLIT_REM: n_state = ffba_pkg::S_SPLIT_CUR;
            ffba_pkg::S_SPLIT_CUR: n_state = ffba_pkg::S_DONE;
            ffba_pkg::S_APPEND:    n_state = ffba_pkg::S_DONE;
            ffba_pkg::S_NX_RD:
                n_state = i_sts.has_next ? ffba_pkg::S_NX_CHK : ffba_pkg::S_CUR_WR;
            ffba_pkg::S_NX_CHK:    n_state = ffba_pkg::S_CUR_WR;
            ffba_pkg::S_CUR_WR:
                n_state = i_sts.merged ? ffba_pkg::S_SHD_RD : ffba_pkg::S_PV;
            ffba_pkg::S_SHD_RD:
                n_state = i_sts.shd_end ? ffba_pkg::S_PV : ffba_pkg::S_SHD_WR;
            ffba_pkg::S_SHD_WR:    n_state = ffba_pkg::S_SHD_RD;
            ffba_pkg::S_PV:
                n_state = i_sts.pv_merge ? ffba_pkg::S_SHD_RD : ffba_pkg::S_DONE;
            ffba_pkg::S_DONE:      if (i_sts.out_free) n_state = ffba_pkg::S_IDLE;
            default:               n_state = ffba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op   = ffba_pkg::OP_NONE;
        o_in_stall = (r_state != ffba_pkg::S_IDLE);
        unique case (r_state)
            ffba_pkg::S_IDLE: if (i_valid) o_ctl.op = ffba_pkg::OP_LOAD;
            ffba_pkg::S_RD: begin
                if (!i_sts.idx_end)         o_ctl.op = ffba_pkg::OP_RD_IDX;
                else if (i_sts.is_free_req) o_ctl.op = ffba_pkg::OP_FIN_UNKNOWN;
            end
            ffba_pkg::S_CHK: begin
                if (!i_sts.hit)             o_ctl.op = ffba_pkg::OP_NEXT;
                else if (i_sts.is_free_req) o_ctl.op = ffba_pkg::OP_HIT_FREE;
                else if (i_sts.tbl_full)    o_ctl.op = ffba_pkg::OP_FIN_FULL;
                else                        o_ctl.op = ffba_pkg::OP_HIT_ALLOC;
            end
            ffba_pkg::S_SHU_RD: if (!i_sts.shu_end) o_ctl.op = ffba_pkg::OP_SHU_RD;
            ffba_pkg::S_SHU_WR:    o_ctl.op = ffba_pkg::OP_SHU_WR;
            ffba_pkg::S_SPLIT_REM: o_ctl.op = ffba_pkg::OP_WR_REM;
            ffba_pkg::S_SPLIT_CUR: o_ctl.op = ffba_pkg::OP_WR_ALLOC;
            ffba_pkg::S_APPEND:    o_ctl.op = ffba_pkg::OP_APPEND;
            ffba_pkg::S_NX_RD: if (i_sts.has_next) o_ctl.op = ffba_pkg::OP_NX_RD;
            ffba_pkg::S_NX_CHK: if (i_sts.next_free) o_ctl.op = ffba_pkg::OP_MERGE_NX;
            ffba_pkg::S_CUR_WR:    o_ctl.op = ffba_pkg::OP_WR_CUR;
            ffba_pkg::S_SHD_RD:
                o_ctl.op = i_sts.shd_end ? ffba_pkg::OP_SHD_END : ffba_pkg::OP_SHD_RD;
            ffba_pkg::S_SHD_WR:    o_ctl.op = ffba_pkg::OP_SHD_WR;
            ffba_pkg::S_PV:
                o_ctl.op = i_sts.pv_merge ? ffba_pkg::OP_MERGE_PV : ffba_pkg::OP_FIN_OK;
            ffba_pkg::S_DONE: if (i_sts.out_free) o_ctl.op = ffba_pkg::OP_EMIT;
            default: ;
        endcase
    end

endmodule

@@ rtl/core/first_fit_block_allocator.sv @@
// First-fit heap block allocator with coalescing of freed neighbors.
// Requests arrive on the input channel (i_valid / o_stall); a transfer
// carries the action (0 allocate, 1 free), the request size and the block
// address. Every request produces exactly one result transfer on the output
// channel (o_valid / i_stall) carrying the data address and a status code.
// The block table lives in a single-port-write, registered-read RAM, and
// each step of the sequencer makes at most one table access. The time a
// request takes is therefore set by the table walk: it grows with every
// entry scanned and with every entry moved when a split opens a slot or a
// merge closes one. The worst case is a free of the second block of a full
// table that merges on both sides.
// One request is processed at a time, and o_stall stays high until the work
// on the current one is done.
// Synchronous reset empties the table and the heap break; the table RAM is
// not cleared, since only entries below the block count are ever read.
// A finished result waits in the output register while i_stall is high;
// the block can already accept the next request, but will not finish it
// until the held result has been transferred.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_block_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_data_address,
    output logic [1:0]  o_status
);

    ffba_pkg::t_ctl ctl;
    ffba_pkg::t_sts sts;

    // Sequencer: walks the table and orders the shift and merge steps.
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_stall (o_stall)
    );

    // Datapath: table RAM, block count, heap break and result register.
    ffba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_out_stall     (i_stall),
        .o_valid         (o_valid),
        .o_data_address  (o_data_address),
        .o_status        (o_status)
    );

    // An accepted request always keeps the input side busy the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a request transfer");

    // Results with an error status never report a nonzero data address.
    a_zero_addr_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ffba_pkg::STS_OK) |-> (o_data_address == 16'd0))
        else $error("nonzero data address with error status");

    // Issuing a result always leaves a valid result in the output register.
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.op == ffba_pkg::OP_EMIT) |=> o_valid)
        else $error("result issued but output not valid");

endmodule

@@ test/first_fit_block_allocator_test.sv @@
module first_fit_block_allocator_test;

    localparam int TABLE_DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    // Shadow copy of the allocator table, heap break and block count.
    typedef struct {
        int unsigned blk_start [TABLE_DEPTH];
        int unsigned blk_size [TABLE_DEPTH];
        bit          blk_free [TABLE_DEPTH];
        int unsigned blk_count;
        int unsigned brk;
    } t_heap_shadow;

    typedef struct {
        logic        action;
        logic [15:0] req_size;
        logic [15:0] blk_addr;
    } t_heap_request;

    typedef struct {
        logic [15:0]       data_addr;
        ffba_pkg::t_status status;
    } t_heap_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [15:0] i_request_size;
    logic [15:0] i_block_address;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_data_address;
    logic [1:0]  o_status;

    t_heap_shadow  plan_heap;     // tracks the heap while requests are planned
    t_heap_shadow  check_heap;    // tracks the heap as transfers are accepted
    t_heap_request pending_requests[$];
    t_heap_reply   expected_replies[$];
    int            send_idle_pct;
    int            recv_idle_pct;
    int            error_count;
    int            quiet_cycles;
    int            requests_sent;
    int            replies_seen;
    int            status_hits[4];

    first_fit_block_allocator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_request_size (i_request_size),
        .i_block_address(i_block_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_address (o_data_address),
        .o_status       (o_status)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic void shadow_clear(ref t_heap_shadow h);
        h.blk_count = 0;
        h.brk = 0;
    endfunction

    function automatic void shadow_open(ref t_heap_shadow h, input int unsigned pos);
        for (int unsigned k = h.blk_count; k > pos; k--) begin
            h.blk_start[k] = h.blk_start[k-1];
            h.blk_size[k] = h.blk_size[k-1];
            h.blk_free[k] = h.blk_free[k-1];
        end
        h.blk_count++;
    endfunction

    function automatic void shadow_close(ref t_heap_shadow h, input int unsigned pos);
        for (int unsigned k = pos; k + 1 < h.blk_count; k++) begin
            h.blk_start[k] = h.blk_start[k+1];
            h.blk_size[k] = h.blk_size[k+1];
            h.blk_free[k] = h.blk_free[k+1];
        end
        h.blk_count--;
    endfunction

    // Applies one request to a shadow heap and returns the reply it causes.
    function automatic t_heap_reply heap_apply(ref t_heap_shadow h, input t_heap_request r);
        t_heap_reply rep;
        int unsigned need;
        int unsigned hit;
        bit          found;
        rep.data_addr = '0;
        rep.status = ffba_pkg::STS_OK;
        found = 0;
        hit = 0;
        if (r.action == 1'b0) begin
            need = int'(r.req_size) + ffba_pkg::HEADER_BYTES;
            for (int unsigned i = 0; i < h.blk_count && !found; i++) begin
                if (h.blk_free[i] && h.blk_size[i] >= need) begin
                    found = 1;
                    hit = i;
                end
            end
            if (found) begin
                if (h.blk_count >= TABLE_DEPTH) begin
                    rep.status = ffba_pkg::STS_TABLE_FULL;
                end else begin
                    shadow_open(h, hit + 1);
                    h.blk_start[hit+1] = h.blk_start[hit] + need;
                    h.blk_size[hit+1] = h.blk_size[hit] - need;
                    h.blk_free[hit+1] = 1;
                    h.blk_size[hit] = r.req_size;
                    h.blk_free[hit] = 0;
                    rep.data_addr = 16'(h.blk_start[hit] + ffba_pkg::HEADER_BYTES);
                end
            end else if (h.brk + need > ffba_pkg::HEAP_BYTES ||
                         h.brk + ffba_pkg::HEADER_BYTES >= ffba_pkg::HEAP_BYTES) begin
                rep.status = ffba_pkg::STS_EXHAUSTED;
            end else if (h.blk_count >= TABLE_DEPTH) begin
                rep.status = ffba_pkg::STS_TABLE_FULL;
            end else begin
                h.blk_start[h.blk_count] = h.brk;
                h.blk_size[h.blk_count] = r.req_size;
                h.blk_free[h.blk_count] = 0;
                h.blk_count++;
                rep.data_addr = 16'(h.brk + ffba_pkg::HEADER_BYTES);
                h.brk = h.brk + need;
            end
        end else begin
            for (int unsigned i = 0; i < h.blk_count && !found; i++) begin
                if (!h.blk_free[i] &&
                    h.blk_start[i] + ffba_pkg::HEADER_BYTES == int'(r.blk_addr)) begin
                    found = 1;
                    hit = i;
                end
            end
            if (!found) begin
                rep.status = ffba_pkg::STS_UNKNOWN;
            end else begin
                h.blk_free[hit] = 1;
                // Absorb a free successor first, then fold into a free predecessor.
                if (hit + 1 < h.blk_count && h.blk_free[hit+1]) begin
                    h.blk_size[hit] += ffba_pkg::HEADER_BYTES + h.blk_size[hit+1];
                    shadow_close(h, hit + 1);
                end
                if (hit > 0 && h.blk_free[hit-1]) begin
                    h.blk_size[hit-1] += ffba_pkg::HEADER_BYTES + h.blk_size[hit];
                    shadow_close(h, hit);
                end
            end
        end
        return rep;
    endfunction

    task automatic queue_request(input logic act, input logic [15:0] sz, input logic [15:0] ad);
        t_heap_request r;
        t_heap_reply   unused;
        r.action = act;
        r.req_size = sz;
        r.blk_addr = ad;
        unused = heap_apply(plan_heap, r);
        pending_requests.push_back(r);
    endtask

    // Returns the data address of a random live block, or a random address if none.
    function automatic logic [15:0] pick_live_address();
        int unsigned live[$];
        for (int unsigned i = 0; i < plan_heap.blk_count; i++) begin
            if (!plan_heap.blk_free[i]) live.push_back(i);
        end
        if (live.size() == 0) return 16'($urandom);
        return 16'(plan_heap.blk_start[live[$urandom_range(live.size() - 1)]] +
                   ffba_pkg::HEADER_BYTES);
    endfunction

    function automatic logic [15:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4) return 16'($urandom);
        if (roll < 12) return 16'($urandom_range(4096));
        return 16'($urandom_range(96));
    endfunction

    task automatic queue_random_burst(input int count);
        int unsigned roll;
        int unsigned alloc_pct;
        for (int n = 0; n < count; n++) begin
            // Alternate between allocation-heavy and free-heavy stretches so that
            // the table fills up to its limit and also drains with merges.
            alloc_pct = ((n / 40) % 2 == 0) ? 75 : 35;
            roll = $urandom_range(99);
            if (roll < alloc_pct) begin
                queue_request(1'b0, pick_size(), 16'($urandom));
            end else if ($urandom_range(99) < 85) begin
                queue_request(1'b1, 16'($urandom), pick_live_address());
            end else begin
                queue_request(1'b1, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Request driver: holds the front request until its transfer completes.
    always @(posedge i_clk) begin
        t_heap_reply rep;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_action <= 1'b0;
            i_request_size <= '0;
            i_block_address <= '0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                rep = heap_apply(check_heap, pending_requests[0]);
                expected_replies.push_back(rep);
                void'(pending_requests.pop_front());
                requests_sent++;
            end
            if ((i_valid ? pending_requests.size() > 0 : pending_requests.size() > 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_action <= pending_requests[0].action;
                i_request_size <= pending_requests[0].req_size;
                i_block_address <= pending_requests[0].blk_addr;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Reply monitor and receiver backpressure.
    always @(posedge i_clk) begin
        t_heap_reply want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
            if (o_valid && !i_stall) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    $error("reply transfer with nothing expected: data_address %0h status %0d",
                           o_data_address, o_status);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    status_hits[want.status]++;
                    if (o_data_address !== want.data_addr) begin
                        $error("data_address expected %0h actual %0h",
                               want.data_addr, o_data_address);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, o_status);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("first_fit_block_allocator_test failed");
                $finish;
            end
        end
    end

    initial begin
        error_count = 0;
        requests_sent = 0;
        replies_seen = 0;
        status_hits = '{0, 0, 0, 0};
        send_idle_pct = 14;
        recv_idle_pct = 48;
        shadow_clear(plan_heap);
        shadow_clear(check_heap);
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty table, size extremes, unknown frees, splits,
        // a zero-sized remainder and merges with a free successor.
        queue_request(1'b1, 16'h0000, 16'h0000);
        queue_request(1'b1, 16'hFFFF, 16'hFFFF);
        queue_request(1'b0, 16'h0000, 16'hFFFF);
        queue_request(1'b0, 16'hFFFF, 16'h0000);
        queue_request(1'b0, 16'd100, 16'h0000);
        queue_request(1'b0, 16'd40, 16'h0000);
        queue_request(1'b0, 16'd8, 16'h0000);
        queue_request(1'b1, 16'h0000, 16'd32);
        queue_request(1'b1, 16'h0000, 16'd32);
        queue_request(1'b0, 16'd84, 16'h0000);
        queue_request(1'b1, 16'h0000, 16'd32);
        queue_request(1'b0, 16'd50, 16'h0000);
        queue_request(1'b1, 16'h0000, 16'd164);
        queue_request(1'b1, 16'h0000, 16'd32);
        queue_request(1'b1, 16'h0000, 16'd16);
        queue_request(1'b1, 16'h0000, 16'd16);
        queue_request(1'b0, 16'd7, 16'h0000);
        queue_request(1'b1, 16'h0000, 16'd17);
        queue_random_burst(170);
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 14;
        queue_random_burst(180);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_burst(180);
        // A few huge requests near the end push the heap break to its limit.
        for (int n = 0; n < 6; n++) queue_request(1'b0, 16'($urandom_range(65535, 20000)), '0);
        wait_drained();
        repeat (200) @(posedge i_clk);

        $display("Covered %0d requests and %0d replies over three backpressure phases.",
                 requests_sent, replies_seen);
        $display("Replies by status: ok %0d, exhausted %0d, table full %0d, unknown %0d.",
                 status_hits[ffba_pkg::STS_OK], status_hits[ffba_pkg::STS_EXHAUSTED],
                 status_hits[ffba_pkg::STS_TABLE_FULL], status_hits[ffba_pkg::STS_UNKNOWN]);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("first_fit_block_allocator_test passed");
        end else begin
            $display("first_fit_block_allocator_test failed");
        end
        $finish;
    end

endmodule
